FILE: src/pap_pkg.sv
// ----------------------------------------------------------------------------
// pap_pkg
// Shared widths and defaults for the polygon area and perimeter block.
// ----------------------------------------------------------------------------
package pap_pkg;

  // coordinate width of one vertex component
  localparam int COORD_BITS    = 16;
  // default number of fraction bits of an edge length
  localparam int DEF_FRAC_BITS = 8;
  // one coordinate difference carries one extra bit
  localparam int MUL_W         = COORD_BITS + 1;
  // sum of two squared differences; even, so the root takes whole digit pairs
  localparam int SQ_W          = 2 * MUL_W;
  // signed running area sum and its unsigned output
  localparam int AREA_W        = 43;
  localparam int AREA_OUT_W    = AREA_W - 1;
  // saturating perimeter sum
  localparam int PERIM_W       = 35;

endpackage

FILE: src/polygon_area_perimeter.sv
// Sequence: an opening vertex is only stored, and a lone closing vertex goes
//   straight to the result; each later vertex runs an edge pass (cross products,
//   squares, square root); a closing vertex runs its own edge pass and then one
//   for the wrap edge before the result; output stall holds the result.
// Throughput: one item at a time; the iterative square root (one bit per
//   cycle) and the shared 17x17 multiplier set the edge time.
// Reset: rst (synchronous) clears the sums, vertex count and handshakes.
// ----------------------------------------------------------------------------
// polygon_area_perimeter
// Shoelace area (doubled, absolute) and fixed-point perimeter of a polygon
// whose vertices arrive one item at a time.
// ----------------------------------------------------------------------------
module polygon_area_perimeter
  import pap_pkg::*;
#(
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] vertex_x,
  input  logic signed [COORD_BITS-1:0] vertex_y,
  input  logic                         last_vertex,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [AREA_OUT_W-1:0]        area_doubled,
  output logic [PERIM_W-1:0]           perimeter_q8,
  output logic                         too_few_vertices
);

  localparam int ROOT_W      = SQ_W / 2 + FRAC_BITS;
  localparam int PROD_W      = 2 * MUL_W;
  localparam int AREA_EXT_W  = AREA_W + 1;
  localparam int PERIM_EXT_W = PERIM_W + 1;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_CROSS_A = 3'd1;
  localparam logic [2:0] ST_CROSS_B = 3'd2;
  localparam logic [2:0] ST_SQ_X    = 3'd3;
  localparam logic [2:0] ST_SQ_Y    = 3'd4;
  localparam logic [2:0] ST_ROOT_GO = 3'd5;
  localparam logic [2:0] ST_ROOT    = 3'd6;
  localparam logic [2:0] ST_EMIT    = 3'd7;

  logic [2:0] state;

  logic signed [COORD_BITS-1:0] first_x, first_y, prev_x, prev_y;
  logic signed [COORD_BITS-1:0] ax, ay, bx, by;
  logic [1:0]                   vertex_count;
  logic                         closing;
  logic                         wrap;
  logic                         err;

  logic signed [AREA_W-1:0]     area_sum;
  logic [PERIM_W-1:0]           perimeter_sum;
  logic signed [PROD_W-1:0]     prod;
  logic signed [PROD_W-1:0]     cross_sum;
  logic [SQ_W-1:0]              sq;

  logic signed [MUL_W-1:0]      dx, dy, mul_a, mul_b;
  logic signed [AREA_EXT_W-1:0] area_next;
  logic [PERIM_EXT_W-1:0]       perim_next;
  logic [AREA_W-1:0]            area_neg, area_mag;
  logic [SQ_W-1:0]              sq_total;

  logic                         in_accept;
  logic                         out_free;
  logic                         root_start;
  logic                         root_done;
  logic [ROOT_W-1:0]            root;

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  assign dx = MUL_W'(bx) - MUL_W'(ax);
  assign dy = MUL_W'(by) - MUL_W'(ay);

  // operand select for the shared multiplier
  always_comb begin
    unique case (state)
      ST_CROSS_A: begin mul_a = MUL_W'(ax); mul_b = MUL_W'(by); end
      ST_CROSS_B: begin mul_a = MUL_W'(bx); mul_b = MUL_W'(ay); end
      ST_SQ_X:    begin mul_a = dx;         mul_b = dx;         end
      ST_SQ_Y:    begin mul_a = dy;         mul_b = dy;         end
      default:    begin mul_a = '0;         mul_b = '0;         end
    endcase
  end

  assign area_next  = AREA_EXT_W'(area_sum) + AREA_EXT_W'(cross_sum);
  assign perim_next = PERIM_EXT_W'(perimeter_sum) + PERIM_EXT_W'(root);
  assign sq_total   = sq + prod[SQ_W-1:0];
  assign root_start = (state == ST_ROOT_GO);

  // magnitude of the area sum; the most negative value clamps to the top
  assign area_neg = '0 - area_sum;
  assign area_mag = area_sum[AREA_W-1] ? area_neg : area_sum;

  pap_isqrt #(
    .OPND_W    (SQ_W),
    .FRAC_BITS (FRAC_BITS)
  ) u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (root_start),
    .opnd  (sq_total),
    .done  (root_done),
    .root  (root)
  );

  // datapath registers
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (in_accept) begin
      first_x <= (vertex_count == 2'd0) ? vertex_x : first_x;
      first_y <= (vertex_count == 2'd0) ? vertex_y : first_y;
      prev_x  <= vertex_x;
      prev_y  <= vertex_y;
      ax      <= prev_x;
      ay      <= prev_y;
      bx      <= vertex_x;
      by      <= vertex_y;
      closing <= last_vertex;
    end
    if (state == ST_CROSS_B) cross_sum <= prod;
    if (state == ST_SQ_X)    cross_sum <= cross_sum - prod;
    if (state == ST_SQ_Y)    sq        <= prod[SQ_W-1:0];
    // wrap edge runs from the closing vertex back to the first one
    if (state == ST_ROOT && root_done && closing && !wrap) begin
      ax <= bx;
      ay <= by;
      bx <= first_x;
      by <= first_y;
    end
  end

  // sequencer, sums and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      vertex_count  <= 2'd0;
      area_sum      <= '0;
      perimeter_sum <= '0;
      wrap          <= 1'b0;
      err           <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != ST_EMIT) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (in_accept) begin
            wrap <= 1'b0;
            if (vertex_count == 2'd0) begin
              vertex_count <= 2'd1;
              if (last_vertex) begin
                err   <= 1'b1;
                state <= ST_EMIT;
              end
            end else begin
              vertex_count <= 2'd2;
              state        <= ST_CROSS_A;
            end
          end
        end
        ST_CROSS_A: state <= ST_CROSS_B;
        ST_CROSS_B: state <= ST_SQ_X;
        ST_SQ_X:    state <= ST_SQ_Y;
        ST_SQ_Y: begin
          if (area_next[AREA_W] != area_next[AREA_W-1]) begin
            area_sum <= area_next[AREA_W] ? {1'b1, {(AREA_W-1){1'b0}}}
                                          : {1'b0, {(AREA_W-1){1'b1}}};
          end else begin
            area_sum <= area_next[AREA_W-1:0];
          end
          state <= ST_ROOT_GO;
        end
        ST_ROOT_GO: state <= ST_ROOT;
        ST_ROOT: begin
          if (root_done) begin
            perimeter_sum <= perim_next[PERIM_W] ? {PERIM_W{1'b1}}
                                                 : perim_next[PERIM_W-1:0];
            priority if (closing && !wrap) begin
              wrap  <= 1'b1;
              state <= ST_CROSS_A;
            end else if (closing) begin
              state <= ST_EMIT;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_EMIT: begin
          // hold the result until the output register is free
          if (out_free) begin
            out_valid        <= 1'b1;
            too_few_vertices <= err;
            area_doubled     <= area_mag[AREA_W-1] ? {AREA_OUT_W{1'b1}}
                                                   : area_mag[AREA_OUT_W-1:0];
            perimeter_q8     <= perimeter_sum;
            vertex_count     <= 2'd0;
            area_sum         <= '0;
            perimeter_sum    <= '0;
            err              <= 1'b0;
            state            <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // a single closing vertex reports zero area and perimeter
  assert property (@(posedge clk) disable iff (rst)
    out_valid && too_few_vertices |-> area_doubled == '0 && perimeter_q8 == '0)
    else $error("error result carries nonzero sums");

  // the root finishes only while the sequencer waits for it
  assert property (@(posedge clk) disable iff (rst)
    root_done |-> state == ST_ROOT)
    else $error("square root done outside its wait state");

  // the vertex count never passes two
  assert property (@(posedge clk) disable iff (rst)
    vertex_count != 2'd3)
    else $error("vertex count out of range");

  // a lone closing vertex goes straight to the result
  assert property (@(posedge clk) disable iff (rst)
    in_accept && vertex_count == 2'd0 && last_vertex |=> state == ST_EMIT && err)
    else $error("single-vertex polygon not flagged");

endmodule

FILE: src/pap_isqrt.sv
// ----------------------------------------------------------------------------
// pap_isqrt
// Iterative integer square root, one result bit per cycle by digit
// recurrence. Returns floor(sqrt(opnd * 4^FRAC_BITS)).
// ----------------------------------------------------------------------------
module pap_isqrt
  import pap_pkg::*;
#(
  parameter int OPND_W    = SQ_W,
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [OPND_W-1:0]                 opnd,
  output logic                              done,
  output logic [OPND_W/2+FRAC_BITS-1:0]     root
);

  localparam int ROOT_W  = OPND_W / 2 + FRAC_BITS;
  localparam int SHIFT_W = OPND_W + 2 * FRAC_BITS;
  localparam int REM_W   = ROOT_W + 2;
  localparam int CNT_W   = $clog2(ROOT_W + 1);

  logic [SHIFT_W-1:0] digits;
  logic [REM_W-1:0]   rem;
  logic [ROOT_W-1:0]  q;
  logic [CNT_W-1:0]   cnt;
  logic               busy;

  logic [REM_W-1:0]   rem_sh;
  logic [REM_W-1:0]   trial;
  logic [REM_W-1:0]   diff;
  logic               fits;

  // bring down the next digit pair and try a one in the next root bit
  assign rem_sh = {rem[REM_W-3:0], digits[SHIFT_W-1 -: 2]};
  assign trial  = {q, 2'b01};
  assign fits   = (rem_sh >= trial);
  assign diff   = rem_sh - trial;
  assign root   = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(ROOT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      digits <= SHIFT_W'(opnd) << (2 * FRAC_BITS);
      rem    <= '0;
      q      <= '0;
    end else if (busy) begin
      digits <= digits << 2;
      rem    <= fits ? diff : rem_sh;
      q      <= {q[ROOT_W-2:0], fits};
    end
  end

endmodule
